// File: sv/slcd_pkg.sv
// Package for the segment LCD RAM and serial frame writer: types, constants, helpers.
`timescale 1ns / 1ps
package slcd_pkg;

  localparam int RAM_WORDS    = 32;
  localparam int MAP_ENTRIES  = 64;
  localparam int MAX_FRAMES   = 32;
  localparam int FLUSH_FRAMES = (RAM_WORDS < MAX_FRAMES) ? RAM_WORDS : MAX_FRAMES;
  localparam int RAM_AW       = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int MAP_AW       = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int FIDX_W       = (FLUSH_FRAMES > 1) ? $clog2(FLUSH_FRAMES) : 1;
  localparam int IDX_W        = 7;

  localparam logic [2:0] SEG_LAST      = 3'd6;
  localparam logic [2:0] FRAME_WR_HDR  = 3'b101;
  localparam logic [3:0] FRAME_CMD_HDR = 4'b1000;
  localparam logic [3:0] WR_BITS       = 4'd13;
  localparam logic [3:0] CMD_BITS      = 4'd12;

  typedef enum logic [2:0] {
    OP_LOAD_MAP = 3'd0,
    OP_DIGIT    = 3'd1,
    OP_SYMBOL   = 3'd2,
    OP_PIXEL    = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_FLUSH    = 3'd5,
    OP_COMMAND  = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_RD,
    ST_MAP_WR,
    ST_FLUSH,
    ST_CMD
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] map_slot;
    logic [3:0] digit_pos;
    logic [3:0] digit_value;
    logic [4:0] pixel_seg;
    logic [1:0] pixel_com;
    logic       pixel_on;
    logic [7:0] command_byte;
  } in_t;

  typedef struct packed {
    logic [12:0] frame;
    logic [3:0]  frame_bits;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [4:0] seg;
    logic [1:0] com;
  } map_ent_t;

  typedef struct packed {
    logic capture;
    logic map_load;
    logic pixel_write;
    logic ram_clear;
    logic map_rd;
    logic seg_apply;
    logic seg_next;
    logic flush_emit;
    logic cmd_emit;
  } cmd_t;

  typedef struct packed {
    opcode_t in_op;
    logic    seg_last;
    logic    flush_last;
    logic    out_free;
  } status_t;

  function automatic logic [6:0] digit_shape(input logic [3:0] v);
    logic [6:0] s;
    unique case (v)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] rev4(input logic [3:0] d);
    return {d[0], d[1], d[2], d[3]};
  endfunction

endpackage

// File: sv/segment_lcd_ram_and_serial_writer_top.sv
// Top level of the segment LCD RAM and serial frame writer.
//
//   channel  | direction | handshake          | payload
//   request  | in        | in_valid/in_stall  | in_data  (slcd_pkg::in_t)
//   result   | out       | out_valid/out_stall| out_data (slcd_pkg::out_t)
//
// Load map, pixel and clear are done on accept. A symbol, once accepted, does one map
// memory read and one RAM update; a digit does both for each of seven segments.
// A flush emits 32 frames, one per cycle while the output is not stalled; a command 1.
// Requests are taken one at a time; a waiting result does not block the next request.
// Reset clears the display RAM and all map valid bits.
`timescale 1ns / 1ps
module segment_lcd_ram_and_serial_writer_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  slcd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output slcd_pkg::out_t out_data
);

  slcd_pkg::cmd_t    cmd;
  slcd_pkg::status_t status;

  slcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  slcd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: sv/slcd_ctrl.sv
// Controller state machine: sequences requests and issues datapath commands.
`timescale 1ns / 1ps
module slcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  slcd_pkg::status_t status,
  output slcd_pkg::cmd_t    cmd
);

  slcd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (status.in_op)
            slcd_pkg::OP_DIGIT, slcd_pkg::OP_SYMBOL: state_next = slcd_pkg::ST_MAP_RD;
            slcd_pkg::OP_FLUSH:                      state_next = slcd_pkg::ST_FLUSH;
            slcd_pkg::OP_COMMAND:                    state_next = slcd_pkg::ST_CMD;
            default:                                 state_next = slcd_pkg::ST_IDLE;
          endcase
        end
      end
      slcd_pkg::ST_MAP_RD: state_next = slcd_pkg::ST_MAP_WR;
      slcd_pkg::ST_MAP_WR: begin
        state_next = status.seg_last ? slcd_pkg::ST_IDLE : slcd_pkg::ST_MAP_RD;
      end
      slcd_pkg::ST_FLUSH: begin
        if (status.out_free && status.flush_last) state_next = slcd_pkg::ST_IDLE;
      end
      slcd_pkg::ST_CMD: begin
        if (status.out_free) state_next = slcd_pkg::ST_IDLE;
      end
      default: state_next = slcd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      slcd_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          unique case (status.in_op)
            slcd_pkg::OP_LOAD_MAP: cmd.map_load    = 1'b1;
            slcd_pkg::OP_PIXEL:    cmd.pixel_write = 1'b1;
            slcd_pkg::OP_CLEAR:    cmd.ram_clear   = 1'b1;
            default:               ;
          endcase
        end
      end
      slcd_pkg::ST_MAP_RD: cmd.map_rd = 1'b1;
      slcd_pkg::ST_MAP_WR: begin
        cmd.seg_apply = 1'b1;
        cmd.seg_next  = !status.seg_last;
      end
      slcd_pkg::ST_FLUSH: cmd.flush_emit = status.out_free;
      slcd_pkg::ST_CMD:   cmd.cmd_emit   = status.out_free;
      default:            ;
    endcase
  end

  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == slcd_pkg::ST_MAP_WR |-> $past(state) == slcd_pkg::ST_MAP_RD)
    else $error("segment apply without map read");

  a_cmd_done: assert property (@(posedge clk) disable iff (rst)
    (state == slcd_pkg::ST_CMD && status.out_free) |=> state == slcd_pkg::ST_IDLE)
    else $error("command frame did not end request");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.map_load, cmd.pixel_write, cmd.ram_clear, cmd.map_rd,
              cmd.seg_apply, cmd.flush_emit, cmd.cmd_emit}))
    else $error("conflicting datapath commands");

endmodule

// File: sv/slcd_dp.sv
// Datapath: display RAM, segment map memory, request register and output register.
`timescale 1ns / 1ps
module slcd_dp (
  input  logic              clk,
  input  logic              rst,
  input  slcd_pkg::in_t     in_data,
  input  slcd_pkg::cmd_t    cmd,
  output slcd_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_stall,
  output slcd_pkg::out_t    out_data
);

  logic [3:0]               ram [slcd_pkg::RAM_WORDS];
  slcd_pkg::map_ent_t       map_mem [slcd_pkg::MAP_ENTRIES];
  logic [slcd_pkg::MAP_ENTRIES-1:0] map_vld;

  slcd_pkg::in_t            req;
  logic [2:0]               seg_cnt;
  logic [slcd_pkg::FIDX_W-1:0] flush_idx;
  slcd_pkg::map_ent_t       map_rd_data;
  logic                     map_rd_ok;

  slcd_pkg::opcode_t        req_op;
  logic                     req_symbol;
  logic [slcd_pkg::IDX_W-1:0] map_idx;
  logic [slcd_pkg::MAP_AW-1:0] map_addr;
  logic                     map_idx_ok;
  logic [6:0]               shape;
  logic                     seg_on;
  logic                     seg_ok;
  logic                     pix_ok;
  logic                     flush_last;
  logic                     out_free;
  logic [3:0]               flush_word;

  assign req_op     = slcd_pkg::opcode_t'(req.opcode);
  assign req_symbol = (req_op == slcd_pkg::OP_SYMBOL);
  assign map_idx    = req_symbol ? slcd_pkg::IDX_W'(req.map_slot)
                                 : slcd_pkg::IDX_W'(req.digit_pos) * slcd_pkg::IDX_W'(7)
                                   + slcd_pkg::IDX_W'(seg_cnt);
  assign map_addr   = slcd_pkg::MAP_AW'(map_idx);
  assign map_idx_ok = (int'(map_idx) < slcd_pkg::MAP_ENTRIES);
  assign shape      = slcd_pkg::digit_shape(req.digit_value);
  assign seg_on     = req_symbol ? req.pixel_on : shape[seg_cnt];
  assign seg_ok     = map_rd_ok && (int'(map_rd_data.seg) < slcd_pkg::RAM_WORDS);
  assign pix_ok     = (int'(in_data.pixel_seg) < slcd_pkg::RAM_WORDS);
  assign flush_last = (int'(flush_idx) == slcd_pkg::FLUSH_FRAMES - 1);
  assign out_free   = !out_valid || !out_stall;
  assign flush_word = ram[slcd_pkg::RAM_AW'(flush_idx)];

  assign status.in_op      = slcd_pkg::opcode_t'(in_data.opcode);
  assign status.seg_last   = req_symbol || (seg_cnt == slcd_pkg::SEG_LAST);
  assign status.flush_last = flush_last;
  assign status.out_free   = out_free;

  // request register and sequencing counters
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cnt   <= '0;
      flush_idx <= '0;
    end else if (cmd.capture) begin
      seg_cnt   <= '0;
      flush_idx <= '0;
    end else begin
      if (cmd.seg_next) seg_cnt <= seg_cnt + 3'd1;
      if (cmd.flush_emit) flush_idx <= flush_idx + slcd_pkg::FIDX_W'(1);
    end
  end

  // segment map: memory for position, flops for valid bits
  always_ff @(posedge clk) begin
    if (cmd.map_load && int'(in_data.map_slot) < slcd_pkg::MAP_ENTRIES) begin
      map_mem[slcd_pkg::MAP_AW'(in_data.map_slot)] <= {in_data.pixel_seg, in_data.pixel_com};
    end
    if (cmd.map_rd) begin
      map_rd_data <= map_mem[map_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld   <= '0;
      map_rd_ok <= 1'b0;
    end else begin
      if (cmd.map_load && int'(in_data.map_slot) < slcd_pkg::MAP_ENTRIES) begin
        map_vld[slcd_pkg::MAP_AW'(in_data.map_slot)] <= in_data.pixel_on;
      end
      if (cmd.map_rd) begin
        map_rd_ok <= map_idx_ok && map_vld[map_addr];
      end
    end
  end

  // display RAM
  always_ff @(posedge clk) begin
    if (rst || cmd.ram_clear) begin
      for (int i = 0; i < slcd_pkg::RAM_WORDS; i++) ram[i] <= '0;
    end else if (cmd.pixel_write && pix_ok) begin
      ram[slcd_pkg::RAM_AW'(in_data.pixel_seg)][in_data.pixel_com] <= in_data.pixel_on;
    end else if (cmd.seg_apply && seg_ok) begin
      ram[slcd_pkg::RAM_AW'(map_rd_data.seg)][map_rd_data.com] <= seg_on;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush_emit || cmd.cmd_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_emit) begin
      out_data.frame      <= {slcd_pkg::FRAME_WR_HDR, 6'(flush_idx), slcd_pkg::rev4(flush_word)};
      out_data.frame_bits <= slcd_pkg::WR_BITS;
      out_data.last       <= flush_last;
    end else if (cmd.cmd_emit) begin
      out_data.frame      <= {1'b0, slcd_pkg::FRAME_CMD_HDR, req.command_byte};
      out_data.frame_bits <= slcd_pkg::CMD_BITS;
      out_data.last       <= 1'b1;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush_emit || cmd.cmd_emit) |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    seg_cnt <= slcd_pkg::SEG_LAST)
    else $error("segment counter past last segment");

  a_flush_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush_emit && flush_last) |=> (out_valid && out_data.last))
    else $error("final flush frame not marked last");

endmodule
